// ===== hw/rtl/tept_pkg.sv =====
package tept_pkg;

    // Table geometry and key format.
    localparam int TABLE_DEPTH = 16384;
    localparam int VERTEX_BITS = 20;
    localparam int MAX_PROBES  = 16;

    localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
    localparam int PROBE_BITS  = $clog2(MAX_PROBES + 1);
    localparam int KEY_BITS    = 2 * VERTEX_BITS + 1;

    // Port field widths.
    localparam int VERT_W = 20;
    localparam int SIDE_W = 21;
    localparam int FACE_W = 20;

    // Hash mixing constants.
    localparam logic [63:0] HASH_C1 = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] HASH_C2 = 64'hBF58476D1CE4E5B9;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_REASSIGN = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    // Local edge positions.
    localparam logic [1:0] EDGE_AB = 2'd0;
    localparam logic [1:0] EDGE_BC = 2'd1;
    localparam logic [1:0] EDGE_CA = 2'd2;

    // One entry of the info store.
    typedef struct packed {
        logic [SIDE_W-1:0] side;
        logic              half;
        logic              owned;
        logic [FACE_W-1:0] face;
        logic [1:0]        edge_pos;
    } t_info;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_EDGE,
        S_HASH_GO,
        S_HASH_WAIT,
        S_PROBE_RD,
        S_PROBE_CHK,
        S_INFO_RD,
        S_INFO_WR,
        S_OPP_RD,
        S_OPP_CHK,
        S_WRITE1,
        S_WRITE2,
        S_EMIT
    } t_state;

    // Build a valid key from two vertex ids.
    function automatic logic [KEY_BITS-1:0] make_key(logic [VERTEX_BITS-1:0] a,
                                                     logic [VERTEX_BITS-1:0] b);
        return {1'b1, a, b};
    endfunction

endpackage

// ===== hw/rtl/tept_hash.sv =====
module tept_hash
    import tept_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [KEY_BITS-1:0] i_key,
    output logic                o_done,
    output logic [IDX_BITS-1:0] o_hash
);

    logic                r_busy;
    logic [2:0]          r_step;
    logic [63:0]         r_k;
    logic [63:0]         r_y;
    logic [63:0]         r_acc;
    logic                r_done;
    logic [IDX_BITS-1:0] r_hash;
    logic [31:0]         mul_a;
    logic [31:0]         mul_b;
    logic [63:0]         prod;
    logic [63:0]         mix;

    // Operand selection for the shared 32x32 multiplier.
    always_comb begin
        mul_a = r_k[31:0];
        mul_b = HASH_C1[31:0];
        case (r_step)
            3'd1: begin mul_a = r_k[63:32]; mul_b = HASH_C1[31:0];  end
            3'd2: begin mul_a = r_k[31:0];  mul_b = HASH_C1[63:32]; end
            3'd4: begin mul_a = r_y[31:0];  mul_b = HASH_C2[31:0];  end
            3'd5: begin mul_a = r_y[63:32]; mul_b = HASH_C2[31:0];  end
            3'd6: begin mul_a = r_y[31:0];  mul_b = HASH_C2[63:32]; end
            default: begin mul_a = r_k[31:0]; mul_b = HASH_C1[31:0]; end
        endcase
    end

    assign prod = 64'(mul_a) * 64'(mul_b);
    assign mix  = r_acc ^ (r_acc >> 32);

    // Each 64-bit product modulo 2^64 is built from three partial products.
    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= 3'd0;
        end else if (!r_busy) begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= 3'd0;
                r_k    <= 64'(i_key);
            end
        end else begin
            r_step <= r_step + 3'd1;
            case (r_step)
                3'd0, 3'd4: r_acc <= prod;
                3'd1, 3'd2, 3'd5, 3'd6: r_acc[63:32] <= r_acc[63:32] + prod[31:0];
                3'd3: r_y <= r_acc ^ (r_acc >> 29);
                default: begin
                    r_hash <= mix[IDX_BITS-1:0];
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_hash = r_hash;

endmodule

// ===== hw/rtl/triangle_edge_pairing_table.sv =====
// Channel  Direction  Handshake             Beat
// command  in         start & !busy         i_vert_a, i_vert_b, i_vert_c
// result   out        o_valid, one cycle    side, face, edge, pairing, status, last
//
// Each triangle gives three result beats, one per edge. A hash runs as a launch,
// eight steps in the hash unit and a result pickup, and a probe of the key memory
// as a read and a check; an edge runs one or two hashes, its probes, an info
// read-modify-write or an insert. A new triangle is taken only once all three beats
// of the last one are out. After reset the key memory is cleared one entry a cycle,
// every entry, with busy high. Results cannot be stalled; each beat is shown for
// one cycle.
module triangle_edge_pairing_table
    import tept_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [VERT_W-1:0] i_vert_a,
    input  logic [VERT_W-1:0] i_vert_b,
    input  logic [VERT_W-1:0] i_vert_c,
    output logic              o_valid,
    output logic [SIDE_W-1:0] o_side_id,
    output logic [FACE_W-1:0] o_face_id,
    output logic [1:0]        o_local_edge,
    output logic              o_half_flag,
    output logic              o_paired,
    output logic [FACE_W-1:0] o_neighbour_face,
    output logic [1:0]        o_neighbour_edge,
    output logic [1:0]        o_status,
    output logic              o_last
);

    t_state r_state, n_state;

    logic [VERTEX_BITS-1:0] r_va, r_vb, r_vc;
    logic [1:0]             r_j;
    logic [FACE_W-1:0]      r_face;
    logic [SIDE_W-1:0]      r_side_cnt;
    logic [KEY_BITS-1:0]    r_probe_key;
    logic                   r_phase;
    logic                   r_hit1;
    logic [PROBE_BITS-1:0]  r_i;
    logic [IDX_BITS-1:0]    r_slot;
    logic [IDX_BITS-1:0]    r_skip;
    logic                   r_skip_en;
    logic [IDX_BITS-1:0]    r_s1, r_s2;
    logic [IDX_BITS-1:0]    r_clr;

    logic [SIDE_W-1:0]      r_side;
    logic                   r_half;
    logic                   r_paired;
    logic [FACE_W-1:0]      r_nface;
    logic [1:0]             r_nedge;
    logic [1:0]             r_status;

    // Memories.
    logic [KEY_BITS-1:0] key_mem [TABLE_DEPTH];
    t_info               info_mem [TABLE_DEPTH];
    logic [KEY_BITS-1:0] r_key_rdata;
    t_info               r_info_rdata;

    logic                key_we;
    logic [IDX_BITS-1:0] key_waddr;
    logic [KEY_BITS-1:0] key_wdata;
    logic                info_we;
    logic [IDX_BITS-1:0] info_waddr;
    t_info               info_wdata;
    logic [IDX_BITS-1:0] info_raddr;

    logic [VERTEX_BITS-1:0] cur_a, cur_b;
    logic [KEY_BITS-1:0]    k1, k2;
    logic                   degen;
    logic [IDX_BITS-1:0]    slot;
    logic                   exhausted;
    logic                   skip_now;
    logic                   hit;
    logic                   empty;
    logic                   hash_start;
    logic                   hash_done;
    logic [IDX_BITS-1:0]    hash_val;

    // Ends of the current edge and its two directed keys.
    always_comb begin
        case (r_j)
            EDGE_AB: begin cur_a = r_va; cur_b = r_vb; end
            EDGE_BC: begin cur_a = r_vb; cur_b = r_vc; end
            default: begin cur_a = r_vc; cur_b = r_va; end
        endcase
    end

    assign k1    = make_key(cur_a, cur_b);
    assign k2    = make_key(cur_b, cur_a);
    assign degen = (cur_a == cur_b);

    // Linear probe position and its outcome.
    assign slot      = hash_val + IDX_BITS'(r_i);
    assign exhausted = (r_i == PROBE_BITS'(MAX_PROBES));
    assign skip_now  = r_skip_en && (slot == r_skip);
    assign hit       = (r_key_rdata == r_probe_key);
    assign empty     = !r_key_rdata[KEY_BITS-1];

    assign hash_start = (r_state == S_HASH_GO);

    tept_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (hash_start),
        .i_key   (r_probe_key),
        .o_done  (hash_done),
        .o_hash  (hash_val)
    );

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == IDX_BITS'(TABLE_DEPTH - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start) n_state = S_EDGE;
            end
            S_EDGE:      n_state = S_HASH_GO;
            S_HASH_GO:   n_state = S_HASH_WAIT;
            S_HASH_WAIT: begin
                if (hash_done) n_state = S_PROBE_RD;
            end
            S_PROBE_RD: begin
                if (exhausted) n_state = S_EMIT;
                else if (!skip_now) n_state = S_PROBE_CHK;
            end
            S_PROBE_CHK: begin
                if (!(hit || empty)) begin
                    n_state = S_PROBE_RD;
                end else if (!r_phase) begin
                    if (hit) n_state = S_INFO_RD;
                    else if (degen) n_state = S_WRITE1;
                    else n_state = S_HASH_GO;
                end else if (r_hit1) begin
                    n_state = hit ? S_OPP_RD : S_EMIT;
                end else begin
                    n_state = empty ? S_WRITE1 : S_EMIT;
                end
            end
            S_INFO_RD: n_state = S_INFO_WR;
            S_INFO_WR: n_state = degen ? S_EMIT : S_HASH_GO;
            S_OPP_RD:  n_state = S_OPP_CHK;
            S_OPP_CHK: n_state = S_EMIT;
            S_WRITE1:  n_state = degen ? S_EMIT : S_WRITE2;
            S_WRITE2:  n_state = S_EMIT;
            S_EMIT:    n_state = (r_j == EDGE_CA) ? S_IDLE : S_EDGE;
            default:   n_state = S_IDLE;
        endcase
    end

    // Memory controls decoded from the state.
    always_comb begin
        key_we     = 1'b0;
        key_waddr  = r_s1;
        key_wdata  = k1;
        info_we    = 1'b0;
        info_waddr = r_s1;
        info_wdata = '{side: r_side_cnt, half: 1'b0, owned: 1'b1,
                       face: r_face, edge_pos: r_j};
        info_raddr = (r_state == S_OPP_RD) ? r_s2 : r_s1;
        unique case (r_state)
            S_CLEAR: begin
                key_we    = 1'b1;
                key_waddr = r_clr;
                key_wdata = '0;
            end
            S_INFO_WR: begin
                info_we    = 1'b1;
                info_wdata = '{side: r_info_rdata.side, half: r_info_rdata.half,
                               owned: 1'b1, face: r_face, edge_pos: r_j};
            end
            S_WRITE1: begin
                key_we  = 1'b1;
                info_we = 1'b1;
            end
            S_WRITE2: begin
                key_we     = 1'b1;
                key_waddr  = r_s2;
                key_wdata  = k2;
                info_we    = 1'b1;
                info_waddr = r_s2;
                info_wdata = '{side: r_side_cnt, half: 1'b1, owned: 1'b0,
                               face: '0, edge_pos: EDGE_AB};
            end
            default: begin
                key_we  = 1'b0;
                info_we = 1'b0;
            end
        endcase
    end

    // Key memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (key_we) key_mem[key_waddr] <= key_wdata;
        r_key_rdata <= key_mem[slot];
    end

    // Info memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (info_we) info_mem[info_waddr] <= info_wdata;
        r_info_rdata <= info_mem[info_raddr];
    end

    // Control counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= '0;
            r_face     <= '0;
            r_side_cnt <= '0;
            r_j        <= EDGE_AB;
        end else begin
            if (r_state == S_CLEAR) r_clr <= r_clr + IDX_BITS'(1);
            if (r_state == S_IDLE && start) r_j <= EDGE_AB;
            if (r_state == S_EMIT) begin
                if (r_j == EDGE_CA) r_face <= r_face + FACE_W'(1);
                else r_j <= r_j + 2'd1;
            end
            if ((r_state == S_WRITE1 && degen) || r_state == S_WRITE2) begin
                r_side_cnt <= r_side_cnt + SIDE_W'(1);
            end
        end
    end

    // Edge datapath: probe sequencing and result fields.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    r_va <= VERTEX_BITS'(i_vert_a);
                    r_vb <= VERTEX_BITS'(i_vert_b);
                    r_vc <= VERTEX_BITS'(i_vert_c);
                end
            end
            S_EDGE: begin
                r_probe_key <= k1;
                r_phase     <= 1'b0;
                r_hit1      <= 1'b0;
                r_skip_en   <= 1'b0;
                r_side      <= '0;
                r_half      <= 1'b0;
                r_paired    <= 1'b0;
                r_nface     <= '0;
                r_nedge     <= EDGE_AB;
                r_status    <= ST_OK;
            end
            S_HASH_WAIT: r_i <= '0;
            S_PROBE_RD: begin
                r_slot <= slot;
                if (exhausted) begin
                    if (!r_phase || !r_hit1) r_status <= ST_FULL;
                end else if (skip_now) begin
                    r_i <= r_i + PROBE_BITS'(1);
                end
            end
            S_PROBE_CHK: begin
                if (!(hit || empty)) begin
                    r_i <= r_i + PROBE_BITS'(1);
                end else if (!r_phase) begin
                    r_s1 <= r_slot;
                    if (hit) begin
                        r_hit1 <= 1'b1;
                    end else if (!degen) begin
                        r_probe_key <= k2;
                        r_phase     <= 1'b1;
                        r_skip      <= r_slot;
                        r_skip_en   <= 1'b1;
                    end
                end else begin
                    r_s2 <= r_slot;
                    if (!r_hit1 && hit) r_status <= ST_FULL;
                end
            end
            S_INFO_WR: begin
                r_side      <= r_info_rdata.side;
                r_half      <= r_info_rdata.half;
                r_status    <= r_info_rdata.owned ? ST_REASSIGN : ST_OK;
                r_probe_key <= k2;
                r_phase     <= 1'b1;
                r_skip_en   <= 1'b0;
            end
            S_OPP_CHK: begin
                if (r_info_rdata.owned) begin
                    r_paired <= 1'b1;
                    r_nface  <= r_info_rdata.face;
                    r_nedge  <= r_info_rdata.edge_pos;
                end
            end
            S_WRITE1: r_side <= r_side_cnt;
            default: begin
            end
        endcase
    end

    // Result beat.
    assign busy             = (r_state != S_IDLE);
    assign o_valid          = (r_state == S_EMIT);
    assign o_side_id        = r_side;
    assign o_face_id        = r_face;
    assign o_local_edge     = r_j;
    assign o_half_flag      = r_half;
    assign o_paired         = r_paired;
    assign o_neighbour_face = r_nface;
    assign o_neighbour_edge = r_nedge;
    assign o_status         = r_status;
    assign o_last           = (r_j == EDGE_CA);

    // A full table stores nothing and reports no side or neighbour.
    a_full_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_FULL |-> o_side_id == '0 && !o_paired && !o_half_flag)
        else $error("full-table result carries side or neighbour data");

    // The face number advances exactly after the third beat of a triangle.
    a_face_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |=> r_face == $past(r_face) + FACE_W'(1))
        else $error("face counter did not advance after last beat");

    // An accepted triangle raises busy and starts at the first edge; busy stays high until its beats are out.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy && r_j == EDGE_AB)
        else $error("accepted triangle did not start at the first edge");

    // Degenerate edges never pair.
    a_degen_unpaired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && degen |-> !o_paired)
        else $error("degenerate edge reported as paired");

endmodule
